/* rtl/core/dds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_pkg
// Shared widths and constants for the disk data separator DPLL.
// ----------------------------------------------------------------------------
package dds_pkg;

  // history ring
  localparam int HISTORY_DEPTH = 16;
  localparam int PTR_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  // field and state widths
  localparam int CMD_W    = 1;
  localparam int CYCLE_W  = 6;
  localparam int CPB_W    = 12;
  localparam int PHASE_W  = 17;
  localparam int OFFSET_W = 16;
  localparam int WLEN_W   = 16;

  // one entry's rounded bit multiple, and the sums over the whole ring
  localparam int M_W      = OFFSET_W + 1;
  localparam int SPACE_W  = OFFSET_W + $clog2(HISTORY_DEPTH + 1);
  localparam int DSUM_W   = M_W + $clog2(HISTORY_DEPTH + 1);

  // shared restoring divider covers every quotient the block needs
  localparam int DIV_W    = DSUM_W;
  localparam int DCNT_W   = $clog2(DIV_W + 1);

  // zero bits emitted per time item
  localparam int MAX_RESULTS = 64;
  localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

  // reset values
  localparam logic [CPB_W-1:0]    CPB_RESET  = CPB_W'(16);
  localparam logic [WLEN_W-1:0]   WLEN_RESET = WLEN_W'(16);
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  // input commands
  localparam logic [CMD_W-1:0] CMD_TIME  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_PULSE = 1'b1;

endpackage

/* rtl/core/dds_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_if
// Valid/ready channels of the data separator: flux events in, bits out.
// ----------------------------------------------------------------------------
interface dds_in_if;
  logic                           valid;
  logic                           ready;
  logic [dds_pkg::CMD_W-1:0]      cmd;
  logic [dds_pkg::CYCLE_W-1:0]    cycle_count;

  modport source (output valid, output cmd, output cycle_count, input ready);
  modport sink   (input valid, input cmd, input cycle_count, output ready);
endinterface

interface dds_out_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic last_of_run;

  modport source (output valid, output data_bit, output last_of_run, input ready);
  modport sink   (input valid, input data_bit, input last_of_run, output ready);
endinterface

/* rtl/core/disk_data_separator_dpll_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_data_separator_dpll_core
// Digital PLL data separator: turns flux pulse timing into a bit stream.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                    Transfer
//  in_ch    in   cmd, cycle_count           valid && ready
//  out_ch   out  data_bit, last_of_run      valid && ready
//  cfg      in   cfg_wdata (bit period)     cfg_we
//
//  Time item: done in idle if no window boundary is crossed, else a divider
//  pass for phase / window length, then one zero bit per cycle unless the
//  output stalls. Pulse item, ignored while the window is filled: each of 16
//  history entries takes a load and a pass of the shared 22-step divider;
//  a nonzero multiple sum adds a window length pass; then pull and result.
//  rst_n is synchronous; the history ring is marked empty at once.
//  in_ch.ready is high only while the sequencer is idle; a held result in
//  the output register does not block the next transfer in.
// ----------------------------------------------------------------------------
module disk_data_separator_dpll_core (
  input  logic                        clk,
  input  logic                        rst_n,
  dds_in_if.sink                      in_ch,
  dds_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [dds_pkg::CPB_W-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TDIV,
    ST_PLOAD,
    ST_PMUL,
    ST_PLEN,
    ST_PULL,
    ST_EMIT
  } state_t;

  state_t                                state_r;

  logic [dds_pkg::CPB_W-1:0]             cpb_r;
  logic [dds_pkg::PHASE_W-1:0]           phase_r;
  logic [dds_pkg::OFFSET_W-1:0]          offset_r;
  logic [dds_pkg::WLEN_W-1:0]            wlen_r;
  logic                                  filled_r;
  logic [dds_pkg::PTR_W-1:0]             ptr_r;
  logic [dds_pkg::PTR_W-1:0]             idx_r;
  logic [dds_pkg::HISTORY_DEPTH-1:0]     ring_vld_r;
  logic [dds_pkg::OFFSET_W-1:0]          ring_mem [dds_pkg::HISTORY_DEPTH];
  logic [dds_pkg::OFFSET_W-1:0]          entry_r;
  logic [dds_pkg::SPACE_W-1:0]           space_sum_r;
  logic [dds_pkg::DSUM_W-1:0]            mult_sum_r;

  // shared divider
  logic [dds_pkg::DIV_W-1:0]             div_rem_r;
  logic [dds_pkg::DIV_W-1:0]             div_quo_r;
  logic [dds_pkg::DIV_W-1:0]             div_dsr_r;
  logic [dds_pkg::DCNT_W-1:0]            div_cnt_r;

  // result sequencing and output register
  logic [dds_pkg::EMIT_W-1:0]            emit_cnt_r;
  logic                                  emit_bit_r;
  logic                                  out_valid_r;
  logic                                  out_bit_r;
  logic                                  out_last_r;

  // combinational helpers
  logic                                  in_xfer;
  logic                                  out_free;
  logic [dds_pkg::CPB_W-1:0]             cpb_eff;
  logic [dds_pkg::WLEN_W-1:0]            wlen_eff;
  logic [dds_pkg::PHASE_W:0]             phase_nxt;
  logic [dds_pkg::OFFSET_W:0]            offset_sum;
  logic [dds_pkg::OFFSET_W-1:0]          offset_nxt;
  logic [dds_pkg::OFFSET_W-1:0]          entry_rd;
  logic [dds_pkg::M_W-1:0]               entry_dvd;
  logic [dds_pkg::DIV_W:0]               div_shift;
  logic [dds_pkg::DIV_W:0]               div_diff;
  logic                                  div_ge;
  logic [dds_pkg::DIV_W-1:0]             crossed;
  logic [dds_pkg::EMIT_W-1:0]            emit_n;
  logic [dds_pkg::WLEN_W-1:0]            wlen_nxt;
  logic signed [dds_pkg::PHASE_W+1:0]    pull_err;
  logic signed [dds_pkg::PHASE_W+1:0]    pull_amt;
  logic signed [dds_pkg::PHASE_W+1:0]    pull_phase;
  logic                                  idx_last;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready        = rst_n && (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_bit    = out_bit_r;
  assign out_ch.last_of_run = out_last_r;

  // zero divisors count as one
  assign cpb_eff  = (cpb_r == '0) ? dds_pkg::CPB_W'(1) : cpb_r;
  assign wlen_eff = (wlen_r == '0) ? dds_pkg::WLEN_W'(1) : wlen_r;

  // advance phase and saturate the pulse offset
  assign phase_nxt  = {1'b0, phase_r} + (dds_pkg::PHASE_W + 1)'(in_ch.cycle_count);
  assign offset_sum = {1'b0, offset_r} + (dds_pkg::OFFSET_W + 1)'(in_ch.cycle_count);
  assign offset_nxt = offset_sum[dds_pkg::OFFSET_W] ? dds_pkg::OFFSET_MAX
                                                    : offset_sum[dds_pkg::OFFSET_W-1:0];

  // history entry under the sweep index; empty slots read as zero
  assign entry_rd  = ring_vld_r[idx_r] ? ring_mem[idx_r] : '0;
  assign entry_dvd = dds_pkg::M_W'(entry_rd) + dds_pkg::M_W'(cpb_eff >> 1);
  assign idx_last  = (idx_r == dds_pkg::PTR_W'(dds_pkg::HISTORY_DEPTH - 1));

  // one restoring division step
  assign div_shift = {div_rem_r, div_quo_r[dds_pkg::DIV_W-1]};
  assign div_diff  = div_shift - {1'b0, div_dsr_r};
  assign div_ge    = !div_diff[dds_pkg::DIV_W];

  // windows crossed, less the one already filled, capped
  assign crossed = div_quo_r - dds_pkg::DIV_W'(filled_r);
  assign emit_n  = (crossed > dds_pkg::DIV_W'(dds_pkg::MAX_RESULTS))
                   ? dds_pkg::EMIT_W'(dds_pkg::MAX_RESULTS)
                   : crossed[dds_pkg::EMIT_W-1:0];

  // new window length, raised to one when the quotient is zero
  assign wlen_nxt = (div_quo_r == '0) ? dds_pkg::WLEN_W'(1)
                                      : div_quo_r[dds_pkg::WLEN_W-1:0];

  // pull phase halfway toward mid-window
  assign pull_err   = $signed({2'b00, phase_r})
                    - $signed((dds_pkg::PHASE_W + 2)'(wlen_r >> 1))
                    + $signed((dds_pkg::PHASE_W + 2)'(1));
  assign pull_amt   = pull_err >>> 1;
  assign pull_phase = $signed({2'b00, phase_r}) - pull_amt;

  // history ring storage
  always_ff @(posedge clk) begin
    if (in_xfer && (in_ch.cmd == dds_pkg::CMD_PULSE) && !filled_r) begin
      ring_mem[ptr_r] <= offset_r;
    end
  end

  // sequencer, datapath state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cpb_r       <= dds_pkg::CPB_RESET;
      phase_r     <= '0;
      offset_r    <= '0;
      wlen_r      <= dds_pkg::WLEN_RESET;
      filled_r    <= 1'b0;
      ptr_r       <= '0;
      idx_r       <= '0;
      ring_vld_r  <= '0;
      div_cnt_r   <= '0;
      emit_cnt_r  <= '0;
      emit_bit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cpb_r <= cfg_wdata;
      end

      // drop the held result once transferred; the emit state reloads it itself
      if (out_valid_r && out_ch.ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      // iterate the divider while it has steps left
      if (div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - dds_pkg::DCNT_W'(1);
        div_rem_r <= div_ge ? div_diff[dds_pkg::DIV_W-1:0] : div_shift[dds_pkg::DIV_W-1:0];
        div_quo_r <= {div_quo_r[dds_pkg::DIV_W-2:0], div_ge};
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_ch.cmd == dds_pkg::CMD_PULSE) begin
              if (!filled_r) begin
                // log offset, then sweep the whole ring
                filled_r          <= 1'b1;
                ring_vld_r[ptr_r] <= 1'b1;
                ptr_r             <= (ptr_r == dds_pkg::PTR_W'(dds_pkg::HISTORY_DEPTH - 1))
                                     ? '0 : ptr_r + dds_pkg::PTR_W'(1);
                offset_r          <= '0;
                idx_r             <= '0;
                space_sum_r       <= '0;
                mult_sum_r        <= '0;
                state_r           <= ST_PLOAD;
              end
            end else begin
              offset_r <= offset_nxt;
              if (phase_nxt < (dds_pkg::PHASE_W + 1)'(wlen_eff)) begin
                phase_r <= phase_nxt[dds_pkg::PHASE_W-1:0];
              end else begin
                div_rem_r <= '0;
                div_quo_r <= dds_pkg::DIV_W'(phase_nxt);
                div_dsr_r <= dds_pkg::DIV_W'(wlen_eff);
                div_cnt_r <= dds_pkg::DCNT_W'(dds_pkg::DIV_W);
                state_r   <= ST_TDIV;
              end
            end
          end
        end

        ST_TDIV: begin
          if (div_cnt_r == '0) begin
            phase_r    <= div_rem_r[dds_pkg::PHASE_W-1:0];
            filled_r   <= 1'b0;
            emit_cnt_r <= emit_n;
            emit_bit_r <= 1'b0;
            state_r    <= (emit_n == '0) ? ST_IDLE : ST_EMIT;
          end
        end

        ST_PLOAD: begin
          // round entry to bit cells: (offset + cpb/2) / cpb
          entry_r   <= entry_rd;
          div_rem_r <= '0;
          div_quo_r <= dds_pkg::DIV_W'(entry_dvd);
          div_dsr_r <= dds_pkg::DIV_W'(cpb_eff);
          div_cnt_r <= dds_pkg::DCNT_W'(dds_pkg::DIV_W);
          state_r   <= ST_PMUL;
        end

        ST_PMUL: begin
          if (div_cnt_r == '0) begin
            logic [dds_pkg::DSUM_W-1:0]  msum_new;
            logic [dds_pkg::SPACE_W-1:0] ssum_new;
            // skip entries with a zero multiple
            msum_new = mult_sum_r;
            ssum_new = space_sum_r;
            if (div_quo_r != '0) begin
              msum_new = mult_sum_r + dds_pkg::DSUM_W'(div_quo_r[dds_pkg::M_W-1:0]);
              ssum_new = space_sum_r + dds_pkg::SPACE_W'(entry_r);
            end
            mult_sum_r  <= msum_new;
            space_sum_r <= ssum_new;
            if (idx_last) begin
              if (msum_new != '0) begin
                div_rem_r <= '0;
                div_quo_r <= dds_pkg::DIV_W'(ssum_new);
                div_dsr_r <= dds_pkg::DIV_W'(msum_new);
                div_cnt_r <= dds_pkg::DCNT_W'(dds_pkg::DIV_W);
                state_r   <= ST_PLEN;
              end else begin
                state_r <= ST_PULL;
              end
            end else begin
              idx_r   <= idx_r + dds_pkg::PTR_W'(1);
              state_r <= ST_PLOAD;
            end
          end
        end

        ST_PLEN: begin
          if (div_cnt_r == '0) begin
            wlen_r  <= wlen_nxt;
            state_r <= ST_PULL;
          end
        end

        ST_PULL: begin
          phase_r    <= pull_phase[dds_pkg::PHASE_W-1:0];
          emit_cnt_r <= dds_pkg::EMIT_W'(1);
          emit_bit_r <= 1'b1;
          state_r    <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_bit_r   <= emit_bit_r;
            out_last_r  <= (emit_cnt_r == dds_pkg::EMIT_W'(1));
            emit_cnt_r  <= emit_cnt_r - dds_pkg::EMIT_W'(1);
            if (emit_cnt_r == dds_pkg::EMIT_W'(1)) begin
              state_r <= ST_IDLE;
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // no transfer in while the divider is mid-run
  a_idle_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (div_cnt_r == '0))
    else $error("input taken while divider busy");

  // a pulse into an empty window marks it filled
  a_pulse_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_ch.cmd == dds_pkg::CMD_PULSE)) |=> filled_r)
    else $error("window not filled after pulse");

  // a stalled output holds the pending run count
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && out_valid_r && !out_ch.ready) |=> $stable(emit_cnt_r))
    else $error("result run advanced while output stalled");

  // ring pointer stays inside the history
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= dds_pkg::PTR_W'(dds_pkg::HISTORY_DEPTH - 1))
    else $error("ring pointer out of range");
`endif

endmodule
